>>> hdl/gpt_pkg.sv
// shared types, register map and helper functions of the pin controller with timer
package gpt_pkg;

   localparam int unsigned DEFAULT_NUM_PINS = 54;
   localparam int unsigned WORD_W           = 32;
   localparam int unsigned MAX_PINS         = 2 * WORD_W;
   localparam int unsigned PIN_FIELD_W      = 54;
   localparam int unsigned OFFSET_W         = 6;
   localparam int unsigned COUNT_W          = 64;
   localparam int unsigned FSEL_WORDS       = 6;
   localparam int unsigned FSEL_PINS        = 10;
   localparam int unsigned FIELD_W          = 3;
   localparam int unsigned FSEL_BITS        = FSEL_PINS * FIELD_W;
   localparam int unsigned FSEL_PIN_LIMIT   = FSEL_WORDS * FSEL_PINS;

   localparam logic [FIELD_W-1:0] FIELD_MASK  = 3'h7;
   localparam logic [FIELD_W-1:0] CODE_OUTPUT = 3'h1;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_READ  = 2'd1,
      OP_WRITE = 2'd2
   } opcode_type;

   typedef enum logic {
      REGION_GPIO  = 1'b0,
      REGION_TIMER = 1'b1
   } region_type;

   localparam logic [OFFSET_W-1:0] OFF_SET       = 6'd7;
   localparam logic [OFFSET_W-1:0] OFF_SET_HI    = 6'd8;
   localparam logic [OFFSET_W-1:0] OFF_CLR       = 6'd10;
   localparam logic [OFFSET_W-1:0] OFF_CLR_HI    = 6'd11;
   localparam logic [OFFSET_W-1:0] OFF_LEV       = 6'd13;
   localparam logic [OFFSET_W-1:0] OFF_LEV_HI    = 6'd14;
   localparam logic [OFFSET_W-1:0] OFF_PUD       = 6'd37;
   localparam logic [OFFSET_W-1:0] OFF_PUDCLK    = 6'd38;
   localparam logic [OFFSET_W-1:0] OFF_PUDCLK_HI = 6'd39;
   localparam logic [OFFSET_W-1:0] OFF_TLO       = 6'd1;
   localparam logic [OFFSET_W-1:0] OFF_THI       = 6'd2;

   localparam logic [1:0] PULL_NONE = 2'd0;
   localparam logic [1:0] PULL_DOWN = 2'd1;
   localparam logic [1:0] PULL_UP   = 2'd2;

   // function-select bits of one word that belong to existing pins
   function automatic logic [FSEL_BITS-1:0] fsel_valid(input int unsigned word_idx,
                                                       input int unsigned num_pins);
      logic [FSEL_BITS-1:0] m;
      m = '0;
      for (int unsigned k = 0; k < FSEL_PINS; k++) begin
         if (word_idx * FSEL_PINS + k < num_pins) begin
            m[FIELD_W*k +: FIELD_W] = FIELD_MASK;
         end
      end
      return m;
   endfunction

   // places a data word at the low or high bank of a full pin vector
   function automatic logic [MAX_PINS-1:0] bank_bits(input logic [WORD_W-1:0] data,
                                                     input logic upper);
      return upper ? {data, {WORD_W{1'b0}}} : {{WORD_W{1'b0}}, data};
   endfunction

endpackage

>>> hdl/gpt_channels.sv
// valid/ready channel interfaces for request and response transactions
interface gpt_req_if
   import gpt_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic [1:0]             opcode;
   logic                   region;
   logic [OFFSET_W-1:0]    word_offset;
   logic [WORD_W-1:0]      write_data;
   logic [PIN_FIELD_W-1:0] pin_inputs;

   modport source (output valid, opcode, region, word_offset, write_data, pin_inputs,
                   input ready);
   modport sink (input valid, opcode, region, word_offset, write_data, pin_inputs,
                 output ready);
endinterface

interface gpt_rsp_if
   import gpt_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic [WORD_W-1:0]      read_data;
   logic [PIN_FIELD_W-1:0] drive_levels;
   logic [PIN_FIELD_W-1:0] drive_enables;
   logic [PIN_FIELD_W-1:0] pullup_mask;
   logic [PIN_FIELD_W-1:0] pulldown_mask;

   modport source (output valid, read_data, drive_levels, drive_enables, pullup_mask,
                   pulldown_mask, input ready);
   modport sink (input valid, read_data, drive_levels, drive_enables, pullup_mask,
                 pulldown_mask, output ready);
endinterface

>>> hdl/gpio_controller_with_timer.sv
// Pin controller with a tick-driven 64-bit microsecond timer behind 32-bit registers.
// Each request transaction is a timer tick, a register read or a register write, and
// each one yields exactly one response transaction carrying the read data and the
// pin drive, enable and pull state after the request took effect. A request is
// captured in an input register and is applied in the cycle it moves into the
// response register, which offers the response; while responses are taken, one
// transaction per cycle is sustained, and the response register lets a new request be
// taken while a finished response still waits. NUM_PINS sets how many pins have
// latches and pull state; pins 60 and up are always inputs.
module gpio_controller_with_timer
   import gpt_pkg::*;
#(
   parameter int unsigned NUM_PINS = DEFAULT_NUM_PINS
) (
   input logic         clock,
   input logic         reset,
   gpt_req_if.sink     req_if,
   gpt_rsp_if.source   rsp_if
);

   localparam int unsigned FSEL_IDX_W = $clog2(FSEL_WORDS);

   // input stage
   logic                   s1_valid_ff;
   logic [1:0]             s1_opcode_ff;
   logic                   s1_region_ff;
   logic [OFFSET_W-1:0]    s1_offset_ff;
   logic [WORD_W-1:0]      s1_data_ff;
   logic [PIN_FIELD_W-1:0] s1_pins_ff;

   // architectural state
   logic [FSEL_BITS-1:0]   fsel_ff [FSEL_WORDS];
   logic [FSEL_BITS-1:0]   fsel_in [FSEL_WORDS];
   logic [NUM_PINS-1:0]    latch_ff, latch_in;
   logic [1:0]             pull_ff, pull_in;
   logic [NUM_PINS-1:0]    pullup_ff, pullup_in;
   logic [NUM_PINS-1:0]    pulldown_ff, pulldown_in;
   logic [COUNT_W-1:0]     count_ff, count_in;

   // response stage
   logic                   rsp_valid_ff;
   logic [WORD_W-1:0]      rsp_read_ff, rsp_read_in;
   logic [PIN_FIELD_W-1:0] rsp_levels_ff, rsp_levels_in;
   logic [PIN_FIELD_W-1:0] rsp_enables_ff, rsp_enables_in;
   logic [PIN_FIELD_W-1:0] rsp_pullup_ff, rsp_pullup_in;
   logic [PIN_FIELD_W-1:0] rsp_pulldown_ff, rsp_pulldown_in;

   logic                   advance;
   logic                   fsel_hit;
   logic [FSEL_IDX_W-1:0]  fsel_idx;
   logic [FSEL_BITS-1:0]   fsel_mask [FSEL_WORDS];
   logic [NUM_PINS-1:0]    en_cur, en_in;
   logic [MAX_PINS-1:0]    pins_wide;
   logic [NUM_PINS-1:0]    pins_n;
   logic [NUM_PINS-1:0]    lev;
   logic [MAX_PINS-1:0]    lev_wide;
   logic                   wr_upper;
   logic [MAX_PINS-1:0]    wr_wide;
   logic [NUM_PINS-1:0]    wr_bits;
   logic [MAX_PINS-1:0]    levels_wide, enables_wide, pullup_wide, pulldown_wide;

   assign advance      = s1_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !s1_valid_ff || advance;

   assign fsel_hit = s1_offset_ff < OFFSET_W'(FSEL_WORDS);
   assign fsel_idx = s1_offset_ff[FSEL_IDX_W-1:0];

   for (genvar w = 0; w < FSEL_WORDS; w++) begin : g_mask
      assign fsel_mask[w] = fsel_valid(w, NUM_PINS);
   end

   for (genvar n = 0; n < NUM_PINS; n++) begin : g_en
      if (n < FSEL_PIN_LIMIT) begin : g_fsel
         assign en_cur[n] = fsel_ff[n/FSEL_PINS][FIELD_W*(n%FSEL_PINS) +: FIELD_W]
                            == CODE_OUTPUT;
         assign en_in[n]  = fsel_in[n/FSEL_PINS][FIELD_W*(n%FSEL_PINS) +: FIELD_W]
                            == CODE_OUTPUT;
      end else begin : g_none
         assign en_cur[n] = 1'b0;
         assign en_in[n]  = 1'b0;
      end
   end

   assign pins_wide = MAX_PINS'(s1_pins_ff);
   assign pins_n    = pins_wide[NUM_PINS-1:0];
   assign lev       = (latch_ff & en_cur) | (pins_n & ~en_cur);
   assign lev_wide  = MAX_PINS'(lev);

   assign wr_upper = (s1_offset_ff == OFF_SET_HI) || (s1_offset_ff == OFF_CLR_HI) ||
                     (s1_offset_ff == OFF_PUDCLK_HI);
   assign wr_wide  = bank_bits(s1_data_ff, wr_upper);
   assign wr_bits  = wr_wide[NUM_PINS-1:0];

   always_comb begin
      fsel_in     = fsel_ff;
      latch_in    = latch_ff;
      pull_in     = pull_ff;
      pullup_in   = pullup_ff;
      pulldown_in = pulldown_ff;
      count_in    = count_ff;
      rsp_read_in = '0;
      if (advance) begin
         case (s1_opcode_ff)
            OP_TICK: begin
               count_in = count_ff + COUNT_W'(1);
            end
            OP_READ: begin
               if (s1_region_ff == REGION_GPIO) begin
                  if (fsel_hit) begin
                     rsp_read_in = WORD_W'(fsel_ff[fsel_idx]);
                  end else begin
                     case (s1_offset_ff)
                        OFF_LEV:    rsp_read_in = lev_wide[WORD_W-1:0];
                        OFF_LEV_HI: rsp_read_in = lev_wide[MAX_PINS-1:WORD_W];
                        OFF_PUD:    rsp_read_in = WORD_W'(pull_ff);
                        default:    rsp_read_in = '0;
                     endcase
                  end
               end else begin
                  case (s1_offset_ff)
                     OFF_TLO: rsp_read_in = count_ff[WORD_W-1:0];
                     OFF_THI: rsp_read_in = count_ff[COUNT_W-1:WORD_W];
                     default: rsp_read_in = '0;
                  endcase
               end
            end
            OP_WRITE: begin
               if (s1_region_ff == REGION_GPIO) begin
                  if (fsel_hit) begin
                     fsel_in[fsel_idx] = s1_data_ff[FSEL_BITS-1:0] & fsel_mask[fsel_idx];
                  end else begin
                     case (s1_offset_ff)
                        OFF_SET, OFF_SET_HI: latch_in = latch_ff | wr_bits;
                        OFF_CLR, OFF_CLR_HI: latch_in = latch_ff & ~wr_bits;
                        OFF_PUD:             pull_in  = s1_data_ff[1:0];
                        OFF_PUDCLK, OFF_PUDCLK_HI: begin
                           case (pull_ff)
                              PULL_NONE: begin
                                 pullup_in   = pullup_ff & ~wr_bits;
                                 pulldown_in = pulldown_ff & ~wr_bits;
                              end
                              PULL_DOWN: begin
                                 pullup_in   = pullup_ff & ~wr_bits;
                                 pulldown_in = pulldown_ff | wr_bits;
                              end
                              PULL_UP: begin
                                 pulldown_in = pulldown_ff & ~wr_bits;
                                 pullup_in   = pullup_ff | wr_bits;
                              end
                              default: ;
                           endcase
                        end
                        default: ;
                     endcase
                  end
               end
            end
            default: ;
         endcase
      end
   end

   assign levels_wide     = MAX_PINS'(latch_in);
   assign enables_wide    = MAX_PINS'(en_in);
   assign pullup_wide     = MAX_PINS'(pullup_in);
   assign pulldown_wide   = MAX_PINS'(pulldown_in);
   assign rsp_levels_in   = levels_wide[PIN_FIELD_W-1:0];
   assign rsp_enables_in  = enables_wide[PIN_FIELD_W-1:0];
   assign rsp_pullup_in   = pullup_wide[PIN_FIELD_W-1:0];
   assign rsp_pulldown_in = pulldown_wide[PIN_FIELD_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fsel_ff      <= '{default: '0};
         latch_ff     <= '0;
         pull_ff      <= PULL_NONE;
         pullup_ff    <= '0;
         pulldown_ff  <= '0;
         count_ff     <= '0;
      end else begin
         if (req_if.ready) begin
            s1_valid_ff <= req_if.valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         fsel_ff     <= fsel_in;
         latch_ff    <= latch_in;
         pull_ff     <= pull_in;
         pullup_ff   <= pullup_in;
         pulldown_ff <= pulldown_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         s1_opcode_ff <= req_if.opcode;
         s1_region_ff <= req_if.region;
         s1_offset_ff <= req_if.word_offset;
         s1_data_ff   <= req_if.write_data;
         s1_pins_ff   <= req_if.pin_inputs;
      end
      if (advance) begin
         rsp_read_ff     <= rsp_read_in;
         rsp_levels_ff   <= rsp_levels_in;
         rsp_enables_ff  <= rsp_enables_in;
         rsp_pullup_ff   <= rsp_pullup_in;
         rsp_pulldown_ff <= rsp_pulldown_in;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.read_data     = rsp_read_ff;
   assign rsp_if.drive_levels  = rsp_levels_ff;
   assign rsp_if.drive_enables = rsp_enables_ff;
   assign rsp_if.pullup_mask   = rsp_pullup_ff;
   assign rsp_if.pulldown_mask = rsp_pulldown_ff;

   // a tick transaction advances the timer by exactly one
   a_tick_count: assert property (@(posedge clock) disable iff (reset)
      advance && (s1_opcode_ff == OP_TICK) |=> count_ff == $past(count_ff) + COUNT_W'(1))
      else $error("timer did not advance on tick");

   // state only changes when a transaction moves into the response register
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(latch_ff) && $stable(count_ff) && $stable(pull_ff) &&
                   $stable(pullup_ff) && $stable(pulldown_ff))
      else $error("state changed without a transaction");

   // a waiting request is not dropped
   a_req_kept: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff && $stable(s1_offset_ff))
      else $error("pending request lost");

   // every applied request produces a response
   a_rsp_made: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("response missing after request applied");

endmodule

>>> sim/tb.sv
// testbench of the pin controller with microsecond timer: random and directed register traffic
`timescale 1ns / 1ps

module tb;
   import gpt_pkg::*;

   localparam int unsigned PINS       = DEFAULT_NUM_PINS;
   localparam logic [63:0] PIN_MASK   = (64'd1 << PINS) - 64'd1;
   localparam logic [1:0]  OP_UNUSED  = 2'd3;
   localparam logic [1:0]  PULL_RSVD  = 2'd3;
   localparam int unsigned RANDOM_TXN = 1150;
   localparam int unsigned CYCLE_LIMIT = 300000;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned SHOWN_MISMATCHES = 10;
   localparam logic [31:0] ALL_OUTPUT = 32'h0924_9249;

   typedef struct packed {
      logic [1:0]             opcode;
      logic                   region;
      logic [OFFSET_W-1:0]    word_offset;
      logic [WORD_W-1:0]      write_data;
      logic [PIN_FIELD_W-1:0] pin_inputs;
   } req_t;

   typedef struct packed {
      logic [WORD_W-1:0]      read_data;
      logic [PIN_FIELD_W-1:0] drive_levels;
      logic [PIN_FIELD_W-1:0] drive_enables;
      logic [PIN_FIELD_W-1:0] pullup_mask;
      logic [PIN_FIELD_W-1:0] pulldown_mask;
   } rsp_t;

   class pin_state_tracker;
      rsp_t              expected_responses[$];
      logic [FSEL_BITS-1:0] fsel_words [FSEL_WORDS];
      logic [63:0]       latch;
      logic [63:0]       pullups;
      logic [63:0]       pulldowns;
      logic [63:0]       usec_count;
      logic [1:0]        pull_sel;
      int unsigned       mismatches;

      function new();
         for (int w = 0; w < FSEL_WORDS; w++) begin
            fsel_words[w] = '0;
         end
         latch      = '0;
         pullups    = '0;
         pulldowns  = '0;
         usec_count = '0;
         pull_sel   = PULL_NONE;
         mismatches = 0;
      endfunction

      function logic [63:0] output_pins();
         logic [63:0] en;
         en = '0;
         for (int w = 0; w < FSEL_WORDS; w++) begin
            for (int k = 0; k < FSEL_PINS; k++) begin
               if (fsel_words[w][FIELD_W*k +: FIELD_W] == CODE_OUTPUT) begin
                  en[w*FSEL_PINS + k] = 1'b1;
               end
            end
         end
         return en & PIN_MASK;
      endfunction

      function void apply_request(req_t r);
         rsp_t                 e;
         logic [63:0]          en;
         logic [63:0]          sel;
         logic [FSEL_BITS-1:0] valid_bits;
         logic [WORD_W-1:0]    rd;
         logic                 upper;
         rd = '0;
         if (r.opcode == OP_TICK) begin
            usec_count = usec_count + 64'd1;
         end else if (r.opcode == OP_READ) begin
            if (r.region == REGION_TIMER) begin
               if (r.word_offset == OFF_TLO) begin
                  rd = usec_count[31:0];
               end else if (r.word_offset == OFF_THI) begin
                  rd = usec_count[63:32];
               end
            end else if (r.word_offset < FSEL_WORDS) begin
               rd = {2'b00, fsel_words[r.word_offset[2:0]]};
            end else if (r.word_offset == OFF_LEV || r.word_offset == OFF_LEV_HI) begin
               en  = output_pins();
               sel = ((latch & en) | ({10'b0, r.pin_inputs} & ~en)) & PIN_MASK;
               rd  = (r.word_offset == OFF_LEV_HI) ? sel[63:32] : sel[31:0];
            end else if (r.word_offset == OFF_PUD) begin
               rd = {30'b0, pull_sel};
            end
         end else if (r.opcode == OP_WRITE && r.region == REGION_GPIO) begin
            upper = (r.word_offset == OFF_SET_HI || r.word_offset == OFF_CLR_HI ||
                     r.word_offset == OFF_PUDCLK_HI);
            sel = (upper ? {r.write_data, 32'b0} : {32'b0, r.write_data}) & PIN_MASK;
            if (r.word_offset < FSEL_WORDS) begin
               valid_bits = '0;
               for (int k = 0; k < FSEL_PINS; k++) begin
                  if (r.word_offset * FSEL_PINS + k < PINS) begin
                     valid_bits[FIELD_W*k +: FIELD_W] = '1;
                  end
               end
               fsel_words[r.word_offset[2:0]] = r.write_data[FSEL_BITS-1:0] & valid_bits;
            end else if (r.word_offset == OFF_SET || r.word_offset == OFF_SET_HI) begin
               latch = latch | sel;
            end else if (r.word_offset == OFF_CLR || r.word_offset == OFF_CLR_HI) begin
               latch = latch & ~sel;
            end else if (r.word_offset == OFF_PUD) begin
               pull_sel = r.write_data[1:0];
            end else if (r.word_offset == OFF_PUDCLK || r.word_offset == OFF_PUDCLK_HI) begin
               case (pull_sel)
                  PULL_NONE: begin
                     pullups   = pullups & ~sel;
                     pulldowns = pulldowns & ~sel;
                  end
                  PULL_DOWN: begin
                     pullups   = pullups & ~sel;
                     pulldowns = pulldowns | sel;
                  end
                  PULL_UP: begin
                     pulldowns = pulldowns & ~sel;
                     pullups   = pullups | sel;
                  end
                  default: begin
                  end
               endcase
            end
         end
         en              = output_pins();
         e.read_data     = rd;
         e.drive_levels  = latch[PIN_FIELD_W-1:0];
         e.drive_enables = en[PIN_FIELD_W-1:0];
         e.pullup_mask   = pullups[PIN_FIELD_W-1:0];
         e.pulldown_mask = pulldowns[PIN_FIELD_W-1:0];
         expected_responses.push_back(e);
      endfunction

      function void check_response(rsp_t a);
         rsp_t e;
         if (expected_responses.size() == 0) begin
            mismatches++;
            if (mismatches <= SHOWN_MISMATCHES) begin
               $display("%0t: response with none outstanding, read_data %h", $realtime,
                        a.read_data);
            end
            return;
         end
         e = expected_responses.pop_front();
         if (a.read_data !== e.read_data || a.drive_levels !== e.drive_levels ||
             a.drive_enables !== e.drive_enables || a.pullup_mask !== e.pullup_mask ||
             a.pulldown_mask !== e.pulldown_mask) begin
            mismatches++;
            if (mismatches <= SHOWN_MISMATCHES) begin
               $display("%0t: mismatch read_data exp %h got %h", $realtime,
                        e.read_data, a.read_data);
               $display("   levels exp %h got %h", e.drive_levels, a.drive_levels);
               $display("   enables exp %h got %h", e.drive_enables, a.drive_enables);
               $display("   pullup exp %h got %h", e.pullup_mask, a.pullup_mask);
               $display("   pulldown exp %h got %h", e.pulldown_mask, a.pulldown_mask);
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int unsigned req_idle_pct;
   int unsigned rsp_idle_pct;
   int unsigned cycle_count;
   pin_state_tracker tracker;

   gpt_req_if req_ch ();
   gpt_rsp_if rsp_ch ();

   gpio_controller_with_timer DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch.sink),
      .rsp_if (rsp_ch.source)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99, 0) >= rsp_idle_pct);
   end

   // transaction monitors
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         tracker.apply_request({req_ch.opcode, req_ch.region, req_ch.word_offset,
                                req_ch.write_data, req_ch.pin_inputs});
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         tracker.check_response({rsp_ch.read_data, rsp_ch.drive_levels,
                                 rsp_ch.drive_enables, rsp_ch.pullup_mask,
                                 rsp_ch.pulldown_mask});
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[gpio_controller_with_timer] ERROR");
         $finish;
      end
   end

   task automatic send(input logic [1:0] op, input logic rgn, input logic [OFFSET_W-1:0] off,
                       input logic [WORD_W-1:0] data, input logic [PIN_FIELD_W-1:0] pins);
      while ($urandom_range(99, 0) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.opcode      <= op;
      req_ch.region      <= rgn;
      req_ch.word_offset <= off;
      req_ch.write_data  <= data;
      req_ch.pin_inputs  <= pins;
      do begin
         @(posedge clock);
      end while (!req_ch.ready);
   endtask

   task automatic send_random();
      logic [1:0]             op;
      logic                   rgn;
      logic [OFFSET_W-1:0]    off;
      logic [WORD_W-1:0]      data;
      logic [PIN_FIELD_W-1:0] pins;
      int unsigned            pick;
      pick = $urandom_range(99, 0);
      op   = (pick < 15) ? OP_TICK : (pick < 20) ? OP_UNUSED : (pick < 55) ? OP_READ : OP_WRITE;
      rgn  = REGION_GPIO;
      data = $urandom();
      pins = PIN_FIELD_W'({$urandom(), $urandom()});
      if ($urandom_range(99, 0) < 20) begin
         off = OFFSET_W'($urandom_range(63, 0));
      end else begin
         pick = $urandom_range(14, 0);
         case (pick)
            6:       off = OFF_SET;
            7:       off = OFF_SET_HI;
            8:       off = OFF_CLR;
            9:       off = OFF_CLR_HI;
            10:      off = OFF_LEV;
            11:      off = OFF_LEV_HI;
            12:      off = OFF_PUD;
            13:      off = OFF_PUDCLK;
            14:      off = OFF_PUDCLK_HI;
            default: off = OFFSET_W'(pick);
         endcase
      end
      if (op == OP_TICK || op == OP_UNUSED) begin
         rgn = 1'($urandom_range(1, 0));
      end else if ($urandom_range(99, 0) < ((op == OP_READ) ? 25 : 10)) begin
         rgn = REGION_TIMER;
         if ($urandom_range(3, 0) != 0) begin
            off = $urandom_range(1, 0) ? OFF_THI : OFF_TLO;
         end
      end
      if (off < FSEL_WORDS) begin
         for (int k = 0; k < FSEL_PINS; k++) begin
            if ($urandom_range(1, 0) != 0) begin
               data[FIELD_W*k +: FIELD_W] = CODE_OUTPUT;
            end
         end
      end
      send(op, rgn, off, data, pins);
   endtask

   initial begin
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.opcode      = '0;
      req_ch.region      = '0;
      req_ch.word_offset = '0;
      req_ch.write_data  = '0;
      req_ch.pin_inputs  = '0;
      req_idle_pct       = 16;
      rsp_idle_pct       = 46;
      tracker            = new();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send(OP_READ,   REGION_GPIO,  6'd0,          '0,            '0);
      send(OP_WRITE,  REGION_GPIO,  6'd0,          '1,            '0);
      send(OP_READ,   REGION_GPIO,  6'd0,          '0,            '1);
      send(OP_WRITE,  REGION_GPIO,  6'd5,          '1,            '0);
      send(OP_READ,   REGION_GPIO,  6'd5,          '0,            '0);
      send(OP_WRITE,  REGION_GPIO,  6'd0,          ALL_OUTPUT,    '0);
      send(OP_WRITE,  REGION_GPIO,  6'd5,          ALL_OUTPUT,    '0);
      send(OP_WRITE,  REGION_GPIO,  OFF_SET,       '1,            '0);
      send(OP_WRITE,  REGION_GPIO,  OFF_SET_HI,    '1,            '0);
      send(OP_READ,   REGION_GPIO,  OFF_SET,       '0,            '1);
      send(OP_READ,   REGION_GPIO,  OFF_LEV,       '0,            '0);
      send(OP_READ,   REGION_GPIO,  OFF_LEV_HI,    '0,            '1);
      send(OP_WRITE,  REGION_GPIO,  OFF_CLR,       '1,            '0);
      send(OP_WRITE,  REGION_GPIO,  OFF_CLR_HI,    32'hAAAA_AAAA, '0);
      send(OP_WRITE,  REGION_GPIO,  OFF_PUD,       32'hFFFF_FFFE, '0);
      send(OP_WRITE,  REGION_GPIO,  OFF_PUDCLK,    '1,            '0);
      send(OP_WRITE,  REGION_GPIO,  OFF_PUD,       {30'b0, PULL_DOWN}, '0);
      send(OP_WRITE,  REGION_GPIO,  OFF_PUDCLK_HI, '1,            '0);
      send(OP_WRITE,  REGION_GPIO,  OFF_PUD,       {30'b0, PULL_RSVD}, '0);
      send(OP_WRITE,  REGION_GPIO,  OFF_PUDCLK,    '1,            '0);
      send(OP_READ,   REGION_GPIO,  OFF_PUD,       '0,            '0);
      send(OP_WRITE,  REGION_GPIO,  OFF_PUD,       {30'b0, PULL_NONE}, '0);
      send(OP_WRITE,  REGION_GPIO,  OFF_PUDCLK,    32'h0000_FFFF, '0);
      send(OP_TICK,   REGION_TIMER, '1,            '1,            '1);
      send(OP_READ,   REGION_TIMER, OFF_TLO,       '0,            '0);
      send(OP_READ,   REGION_TIMER, OFF_THI,       '0,            '0);
      send(OP_WRITE,  REGION_TIMER, OFF_TLO,       '1,            '0);
      send(OP_UNUSED, REGION_GPIO,  OFF_SET,       '1,            '1);
      send(OP_WRITE,  REGION_GPIO,  6'd63,         '1,            '0);
      send(OP_READ,   REGION_GPIO,  6'd63,         '0,            '1);
      send(OP_READ,   REGION_TIMER, 6'd0,          '0,            '1);

      for (int phase = 0; phase < 3; phase++) begin
         req_idle_pct = (phase == 0) ? 16 : (phase == 1) ? 46 : 0;
         rsp_idle_pct = (phase == 0) ? 46 : (phase == 1) ? 16 : 0;
         for (int n = 0; n < RANDOM_TXN / 3; n++) begin
            send_random();
         end
      end
      req_ch.valid <= 1'b0;

      while (tracker.expected_responses.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.expected_responses.size() == 0) begin
         $display("[gpio_controller_with_timer] OK");
      end else begin
         $display("[gpio_controller_with_timer] ERROR");
      end
      $finish;
   end

endmodule
